FILE: rtl/core/piecewise_linear_eval_macros.svh
// Assertion macros for the piecewise linear evaluator.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef PIECEWISE_LINEAR_EVAL_MACROS_SVH
`define PIECEWISE_LINEAR_EVAL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pwl_pkg.sv
// Shared constants and types for the piecewise linear evaluator.
// No dependencies; used by pwl_table, pwl_divu and piecewise_linear_eval.
package pwl_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int QUERY_W     = 32;
  localparam int ENTRY_W     = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int COUNT_W     = 5;
  localparam int VALUE_W     = 16;
  localparam int MIN_POINTS  = 2;
  localparam int VALUE_MAX   = 32767;
  localparam int VALUE_MIN   = -32768;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/pwl_table.sv
// Breakpoint table: one write port, one read port with registered read data.
// Depends on pwl_pkg for the control struct.
module pwl_table #(
  parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pwl_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  pwl_pkg::tbl_ctl_t            ctl,
  input  logic [IDX_W-1:0]             waddr,
  input  logic signed [COORD_BITS-1:0] wdata_x,
  input  logic signed [COORD_BITS-1:0] wdata_y,
  input  logic [IDX_W-1:0]             raddr,
  output logic signed [COORD_BITS-1:0] rdata_x,
  output logic signed [COORD_BITS-1:0] rdata_y
);

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= {wdata_x, wdata_y};
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata_x = $signed(rdata_r[2*COORD_BITS-1:COORD_BITS]);
  assign rdata_y = $signed(rdata_r[COORD_BITS-1:0]);

endmodule

FILE: rtl/core/pwl_divu.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pwl_pkg for the status struct; shared by wrap and interpolation.
module pwl_divu #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output pwl_pkg::div_stat_t    stat,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W+1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  always_comb begin
    trial     = {rem_r, quo_r[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = (trial >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/piecewise_linear_eval.sv
// Write item: no result. Evaluate with fewer than two points: result in the next cycle.
// Evaluate otherwise: two table reads, a wrap divide when the query leaves the domain
// and the span is positive, a forward then a backward table scan, a multiply, then a divide;
// an exact match ends the scan early and equal bracket x skips the divide. One item at a time.
// Reset clears control and point_count; table contents are undefined until written.
`include "piecewise_linear_eval_macros.svh"

module piecewise_linear_eval #(
  parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pwl_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     in_opcode,
  input  logic [pwl_pkg::ENTRY_IDX_W-1:0]          in_entry_index,
  input  logic signed [pwl_pkg::ENTRY_W-1:0]       in_entry_x,
  input  logic signed [pwl_pkg::ENTRY_W-1:0]       in_entry_y,
  input  logic signed [pwl_pkg::QUERY_W-1:0]       in_query_x,
  output logic                                     out_valid,
  output logic signed [pwl_pkg::VALUE_W-1:0]       out_value,
  output logic                                     out_too_few_points,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [pwl_pkg::COUNT_W-1:0]              cfg_point_count
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int NUM_W  = $clog2(MAX_POINTS+1);
  localparam int SPAN_W = COORD_BITS+1;
  localparam int D_W    = pwl_pkg::QUERY_W+1;
  localparam int P_W    = 2*SPAN_W;
  localparam int SUM_W  = P_W+1;
  localparam int DIV_W  = (P_W > D_W) ? P_W : D_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_WRAP,
    S_MOD_WAIT,
    S_FWD,
    S_BWD,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

  state_t                              state_r, state_nxt;
  logic [pwl_pkg::COUNT_W-1:0]         point_count_r, point_count_nxt;
  logic signed [pwl_pkg::QUERY_W-1:0]  qx_r, qx_nxt;
  logic signed [COORD_BITS-1:0]        ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [COORD_BITS-1:0]        bx_r, bx_nxt, by_r, by_nxt;
  logic signed [COORD_BITS-1:0]        xe_r, xe_nxt;
  logic                                neg_r, neg_nxt;
  logic [IDX_W-1:0]                    iidx_r, iidx_nxt;
  logic                                idone_r, idone_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  logic                                rd_last_r, rd_last_nxt;
  logic signed [P_W-1:0]               prod_r, prod_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [pwl_pkg::VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                                out_few_r, out_few_nxt;

  pwl_pkg::tbl_ctl_t            tbl_ctl;
  logic [IDX_W-1:0]             tbl_raddr;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;

  pwl_pkg::div_stat_t div_stat;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [SPAN_W-1:0]  div_divisor;
  logic [DIV_W-1:0]   div_quo;
  logic [SPAN_W-1:0]  div_rem;

  logic [NUM_W-1:0]             n_eff;
  logic                         few;
  logic [IDX_W-1:0]             last_idx, prev_idx;
  logic signed [D_W-1:0]        q_ext, fx_ext, lx_ext, diff;
  logic [D_W-1:0]               diff_mag;
  logic signed [SPAN_W-1:0]     span_c, dy, dxq, den;
  logic                         need_wrap, span_pos;
  logic [SPAN_W-1:0]            rem_fix, den_mag;
  logic signed [SPAN_W:0]       xe_sum;
  logic signed [P_W-1:0]        prod_c;
  logic [P_W-1:0]               prod_mag;
  logic signed [SUM_W-1:0]      quo_s, sum;
  logic                         wr_accept;

  function automatic logic signed [pwl_pkg::VALUE_W-1:0] sat16(
    input logic signed [SUM_W-1:0] v
  );
    if (v > SUM_W'(pwl_pkg::VALUE_MAX)) begin
      return pwl_pkg::VALUE_W'(pwl_pkg::VALUE_MAX);
    end else if (v < SUM_W'(pwl_pkg::VALUE_MIN)) begin
      return pwl_pkg::VALUE_W'(pwl_pkg::VALUE_MIN);
    end
    return v[pwl_pkg::VALUE_W-1:0];
  endfunction

  pwl_table #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .waddr   (IDX_W'(in_entry_index)),
    .wdata_x ($signed(COORD_BITS'($unsigned(in_entry_x)))),
    .wdata_y ($signed(COORD_BITS'($unsigned(in_entry_y)))),
    .raddr   (tbl_raddr),
    .rdata_x (rd_x),
    .rdata_y (rd_y)
  );

  pwl_divu #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (SPAN_W)
  ) u_divu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Datapath helpers
  always_comb begin
    n_eff    = (int'(point_count_r) > MAX_POINTS) ? NUM_W'(MAX_POINTS)
                                                  : NUM_W'(point_count_r);
    few      = (n_eff < NUM_W'(pwl_pkg::MIN_POINTS));
    last_idx = IDX_W'(n_eff - NUM_W'(1));
    prev_idx = IDX_W'(n_eff - NUM_W'(2));

    // rd_x holds the last point's x while in S_CHK_WRAP
    q_ext     = D_W'(qx_r);
    fx_ext    = D_W'(bx_r);
    lx_ext    = D_W'(rd_x);
    diff      = q_ext - fx_ext;
    diff_mag  = diff[D_W-1] ? $unsigned(-diff) : $unsigned(diff);
    span_c    = SPAN_W'(rd_x) - SPAN_W'(bx_r);
    need_wrap = (q_ext > lx_ext) || (q_ext < fx_ext);
    span_pos  = !span_c[SPAN_W-1] && (span_c != '0);

    // floored modulo: fold a negative offset back from the span
    den     = SPAN_W'(ax_r) - SPAN_W'(bx_r);
    rem_fix = (neg_r && (div_rem != '0)) ? ($unsigned(den) - div_rem) : div_rem;
    xe_sum  = (SPAN_W+1)'(bx_r) + $signed({1'b0, rem_fix});

    dy     = SPAN_W'(ay_r) - SPAN_W'(by_r);
    dxq    = SPAN_W'(xe_r) - SPAN_W'(bx_r);
    prod_c = P_W'(dy) * P_W'(dxq);

    den_mag  = den[SPAN_W-1] ? $unsigned(-den) : $unsigned(den);
    prod_mag = prod_r[P_W-1] ? $unsigned(-prod_r) : $unsigned(prod_r);

    quo_s = $signed({1'b0, div_quo[P_W-1:0]});
    sum   = SUM_W'(by_r) + (neg_r ? -quo_s : quo_s);

    div_start    = ((state_r == S_CHK_WRAP) && need_wrap && span_pos)
                   || (state_r == S_DIV_START);
    div_dividend = (state_r == S_DIV_START) ? DIV_W'(prod_mag) : DIV_W'(diff_mag);
    div_divisor  = (state_r == S_DIV_START) ? den_mag : $unsigned(span_c);
  end

  // Control
  always_comb begin
    state_nxt       = state_r;
    point_count_nxt = point_count_r;
    qx_nxt          = qx_r;
    ax_nxt          = ax_r;
    ay_nxt          = ay_r;
    bx_nxt          = bx_r;
    by_nxt          = by_r;
    xe_nxt          = xe_r;
    neg_nxt         = neg_r;
    iidx_nxt        = iidx_r;
    idone_nxt       = idone_r;
    rd_vld_nxt      = 1'b0;
    rd_last_nxt     = rd_last_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = 1'b0;
    out_value_nxt   = out_value_r;
    out_few_nxt     = out_few_r;
    tbl_ctl.wr_en   = 1'b0;
    tbl_ctl.rd_en   = 1'b0;
    tbl_raddr       = iidx_r;

    if (cfg_valid && cfg_ready) begin
      point_count_nxt = cfg_point_count;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == pwl_pkg::OP_WRITE) begin
            // drop writes beyond the table
            tbl_ctl.wr_en = (int'(in_entry_index) < MAX_POINTS);
          end else begin
            qx_nxt = in_query_x;
            if (few) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_few_nxt   = 1'b1;
            end else begin
              tbl_ctl.rd_en = 1'b1;
              tbl_raddr     = '0;
              state_nxt     = S_RD_FIRST;
            end
          end
        end
      end
      S_RD_FIRST: begin
        bx_nxt        = rd_x;
        by_nxt        = rd_y;
        tbl_ctl.rd_en = 1'b1;
        tbl_raddr     = last_idx;
        state_nxt     = S_CHK_WRAP;
      end
      S_CHK_WRAP: begin
        ax_nxt    = rd_x;
        ay_nxt    = rd_y;
        neg_nxt   = diff[D_W-1];
        iidx_nxt  = IDX_W'(1);
        idone_nxt = 1'b0;
        if (need_wrap) begin
          if (span_pos) begin
            state_nxt = S_MOD_WAIT;
          end else begin
            xe_nxt    = bx_r;
            state_nxt = S_FWD;
          end
        end else begin
          xe_nxt    = COORD_BITS'(qx_r);
          state_nxt = S_FWD;
        end
      end
      S_MOD_WAIT: begin
        if (div_stat.done) begin
          xe_nxt    = COORD_BITS'(xe_sum);
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        if (!idone_r) begin
          tbl_ctl.rd_en = 1'b1;
          rd_vld_nxt    = 1'b1;
          rd_last_nxt   = (iidx_r == last_idx);
          idone_nxt     = (iidx_r == last_idx);
          iidx_nxt      = iidx_r + IDX_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_x == xe_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = sat16(SUM_W'(rd_y));
            out_few_nxt   = 1'b0;
            rd_vld_nxt    = 1'b0;
            state_nxt     = S_IDLE;
          end else if ((rd_x > xe_r) || rd_last_r) begin
            if (rd_x > xe_r) begin
              ax_nxt = rd_x;
              ay_nxt = rd_y;
            end
            // discard the read in flight and restart downward from the second-to-last point
            rd_vld_nxt = 1'b0;
            iidx_nxt   = prev_idx;
            idone_nxt  = 1'b0;
            state_nxt  = S_BWD;
          end
        end
      end
      S_BWD: begin
        if (!idone_r) begin
          tbl_ctl.rd_en = 1'b1;
          rd_vld_nxt    = 1'b1;
          rd_last_nxt   = (iidx_r == '0);
          idone_nxt     = (iidx_r == '0);
          iidx_nxt      = iidx_r - IDX_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_x == xe_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = sat16(SUM_W'(rd_y));
            out_few_nxt   = 1'b0;
            rd_vld_nxt    = 1'b0;
            state_nxt     = S_IDLE;
          end else if ((rd_x < xe_r) || rd_last_r) begin
            if (rd_x < xe_r) begin
              bx_nxt = rd_x;
              by_nxt = rd_y;
            end
            rd_vld_nxt = 1'b0;
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (ax_r == bx_r) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sat16(SUM_W'(by_r));
          out_few_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          prod_nxt  = prod_c;
          state_nxt = S_DIV_START;
        end
      end
      S_DIV_START: begin
        neg_nxt   = prod_r[P_W-1] ^ den[SPAN_W-1];
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sat16(sum);
          out_few_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      idone_r       <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      point_count_r <= point_count_nxt;
      idone_r       <= idone_nxt;
      rd_vld_r      <= rd_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    qx_r        <= qx_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    xe_r        <= xe_nxt;
    neg_r       <= neg_nxt;
    iidx_r      <= iidx_nxt;
    rd_last_r   <= rd_last_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_few_r   <= out_few_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = !busy;
  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_too_few_points = out_few_r;
  assign wr_accept          = start && !busy && (in_opcode == pwl_pkg::OP_WRITE);

  `PWL_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `PWL_ASSERT_NEXT(a_write_no_result, wr_accept, !out_valid, "write item produced a result")
  `PWL_ASSERT_SAME(a_done_gives_result, $fell(busy), out_valid, "evaluation gave no result")

endmodule
